// File: src/bmhq_pkg.sv
// Shared types and constants for the binary max-heap queue.
package bmhq_pkg;

    localparam int CAPACITY = 1024;
    localparam int KEY_W    = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 3;
    localparam int STAT_W   = 2;

    localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE_MAX = 3'd1;
    localparam logic [OP_W-1:0] OP_UPDATE     = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE_AT  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_POS  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [IDX_W-1:0]        pos;
        logic signed [KEY_W-1:0] key;
    } cmd_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] removed_key;
        logic [CNT_W-1:0]        entry_total;
        logic [STAT_W-1:0]       status;
    } res_t;

endpackage

// File: src/bmhq_engine.sv
// Heap engine: key memory, entry count and the sift sequencer.
module bmhq_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  bmhq_pkg::cmd_t  cmd,
    output logic            res_valid,
    input  logic            res_ready,
    output bmhq_pkg::res_t  res
);
    import bmhq_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_LOAD   = 7'b0000010,
        S_PREP   = 7'b0000100,
        S_DOWN   = 7'b0001000,
        S_UP     = 7'b0010000,
        S_WRITE  = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [IDX_W-1:0]        slot_reg, slot_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [KEY_W-1:0] removed_reg, removed_next;
    logic [STAT_W-1:0]       status_reg, status_next;
    logic                    down_reg, down_next;

    logic signed [KEY_W-1:0] mem [CAPACITY];
    logic signed [KEY_W-1:0] rd_a_reg, rd_b_reg;
    logic [IDX_W-1:0]        ra_addr, rb_addr, wr_addr;
    logic signed [KEY_W-1:0] wr_data;
    logic                    wr_en;

    logic                    start;
    logic [CNT_W-1:0]        half_cnt;
    logic [CNT_W-1:0]        left_w;
    logic                    right_ok;
    logic                    pick_right;
    logic [IDX_W-1:0]        child_idx;
    logic signed [KEY_W-1:0] child_key;
    logic [IDX_W-1:0]        parent_idx;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[ra_addr];
        rd_b_reg <= mem[rb_addr];
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign start     = cmd_valid && cmd_ready;
    assign res_valid = (state_reg == S_FINISH);

    assign res.removed_key = removed_reg;
    assign res.entry_total = count_reg;
    assign res.status      = status_reg;

    assign half_cnt   = count_reg >> 1;
    assign left_w     = CNT_W'({slot_reg, 1'b1});
    assign right_ok   = left_w < (count_reg - 1'b1);
    assign pick_right = right_ok && (rd_b_reg > rd_a_reg);
    assign child_key  = pick_right ? rd_b_reg : rd_a_reg;
    assign child_idx  = left_w[IDX_W-1:0] + IDX_W'(pick_right);
    assign parent_idx = (slot_reg - 1'b1) >> 1;

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        pos_next     = pos_reg;
        key_next     = key_reg;
        slot_next    = slot_reg;
        count_next   = count_reg;
        removed_next = removed_reg;
        status_next  = status_reg;
        down_next    = down_reg;
        ra_addr      = '0;
        rb_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = slot_reg;
        wr_data      = key_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next      = cmd.op;
                    pos_next     = cmd.pos;
                    key_next     = cmd.key;
                    removed_next = '0;
                    status_next  = ST_OK;
                    state_next   = S_FINISH;
                    unique case (cmd.op)
                        OP_INSERT:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                slot_next  = count_reg[IDX_W-1:0];
                                count_next = count_reg + 1'b1;
                                down_next  = 1'b0;
                                state_next = S_PREP;
                            end
                        end
                        OP_REMOVE_MAX:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                rb_addr    = count_next[IDX_W-1:0];
                                state_next = S_LOAD;
                            end
                        end
                        OP_UPDATE, OP_REMOVE_AT:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (CNT_W'(cmd.pos) >= count_reg)
                            begin
                                status_next = ST_BAD_POS;
                            end
                            else
                            begin
                                if (cmd.op == OP_REMOVE_AT)
                                begin
                                    count_next = count_reg - 1'b1;
                                end
                                ra_addr    = cmd.pos;
                                rb_addr    = count_next[IDX_W-1:0];
                                state_next = S_LOAD;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                state_next = S_PREP;
                unique case (op_reg)
                    OP_REMOVE_MAX:
                    begin
                        removed_next = rd_a_reg;
                        key_next     = rd_b_reg;
                        slot_next    = '0;
                        down_next    = 1'b1;
                        if (count_reg == '0)
                        begin
                            state_next = S_FINISH;
                        end
                    end
                    OP_UPDATE:
                    begin
                        slot_next = pos_reg;
                        down_next = key_reg < rd_a_reg;
                    end
                    OP_REMOVE_AT:
                    begin
                        key_next  = rd_b_reg;
                        slot_next = pos_reg;
                        down_next = rd_b_reg < rd_a_reg;
                        if (CNT_W'(pos_reg) == count_reg)
                        begin
                            state_next = S_FINISH;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_PREP:
            begin
                state_next = S_WRITE;
                if (down_reg)
                begin
                    if (CNT_W'(slot_reg) < half_cnt)
                    begin
                        ra_addr    = left_w[IDX_W-1:0];
                        rb_addr    = left_w[IDX_W-1:0] + 1'b1;
                        state_next = S_DOWN;
                    end
                end
                else if (slot_reg != '0)
                begin
                    ra_addr    = parent_idx;
                    state_next = S_UP;
                end
            end
            S_DOWN:
            begin
                wr_en = 1'b1;
                if (child_key <= key_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    wr_data   = child_key;
                    slot_next = child_idx;
                    if (CNT_W'(child_idx) < half_cnt)
                    begin
                        ra_addr = {child_idx[IDX_W-2:0], 1'b1};
                        rb_addr = {child_idx[IDX_W-2:0], 1'b1} + 1'b1;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_UP:
            begin
                wr_en = 1'b1;
                if (rd_a_reg >= key_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    wr_data   = rd_a_reg;
                    slot_next = parent_idx;
                    if (parent_idx != '0)
                    begin
                        ra_addr = (parent_idx - 1'b1) >> 1;
                    end
                    else
                    begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_WRITE:
            begin
                wr_en      = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        pos_reg     <= pos_next;
        key_reg     <= key_next;
        slot_reg    <= slot_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
        down_reg    <= down_next;
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_DOWN || state_reg == S_UP || state_reg == S_WRITE))
        else $error("memory written outside a sift");

    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> state_reg != S_IDLE)
        else $error("accepted item did not start");

    a_down_slot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DOWN |-> CNT_W'(slot_reg) < half_cnt)
        else $error("sift down on a leaf");

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");
`endif

endmodule

// File: src/binary_max_heap_queue_unit.sv
// Binary max-heap queue: stream ports, result register and the heap engine.
// Clear, error and unknown operations go straight to the result; a remove that leaves nothing
// to sift ends after the key read, and insert and the other operations sift level by level
// through the heap; one item at a time.
// The sift moves one level per cycle, bounded by the two-read, one-write key memory.
// Reset empties the heap and clears control state; the key memory itself is not cleared.
module binary_max_heap_queue_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // position [9:0], key_value [41:10]
    input  logic [2:0]  s_axis_tuser,  // operation [2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // removed_key [31:0], entry_total [42:32]
    output logic [1:0]  m_axis_tuser   // status [1:0]
);
    import bmhq_pkg::*;

    cmd_t cmd;
    res_t res;
    logic res_valid;
    logic res_ready;
    logic out_valid_reg;
    res_t out_res_reg;

    assign cmd.op  = s_axis_tuser;
    assign cmd.pos = s_axis_tdata[IDX_W-1:0];
    assign cmd.key = s_axis_tdata[IDX_W+KEY_W-1:IDX_W];

    bmhq_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_axis_tvalid),
        .cmd_ready (s_axis_tready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_res_reg.entry_total, out_res_reg.removed_key};
    assign m_axis_tuser  = out_res_reg.status;

endmodule
